>>> rtl/core/pwm_period_duty_register_calc_defines.svh
// Assertion helpers for the PWM compare calculator.
// Both expect clk and rst_n in the scope where they are used.
`ifndef PWM_PERIOD_DUTY_REGISTER_CALC_DEFINES_SVH
`define PWM_PERIOD_DUTY_REGISTER_CALC_DEFINES_SVH

`ifndef SYNTHESIS

`define PWMCALC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwmcalc check failed");

`define PWMCALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwmcalc check failed");

`else

`define PWMCALC_ASSERT_NOW(lbl, ante, cons)

`define PWMCALC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/pwmcalc_pkg.sv
package pwmcalc_pkg;

  localparam int QUOT_W = 32;
  localparam int CNT_W  = $clog2(QUOT_W);

  typedef enum logic [1:0] {
    CFG_SRC_CLOCK = 2'd0,
    CFG_PRESCALE  = 2'd1,
    CFG_ALIGN     = 2'd2,
    CFG_CHAN_B    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALIGN_SCENTER = 2'd0,
    ALIGN_CENTER  = 2'd1,
    ALIGN_SEDGE   = 2'd2,
    ALIGN_EDGE    = 2'd3
  } align_t;

  localparam logic [31:0] SRC_CLOCK_RST = 32'd150000000;

  typedef struct packed {
    logic [31:0] freq_hz;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
  } pwmcalc_in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] start_count;
    logic [15:0] mid_count;
    logic [15:0] end_count;
    logic [15:0] a_on_count;
    logic [15:0] a_off_count;
    logic [15:0] b_on_count;
    logic [15:0] b_off_count;
  } pwmcalc_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_a;
    logic mul_b;
    logic update;
  } pwmcalc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULA,
    ST_MULB,
    ST_UPD,
    ST_DONE
  } pwmcalc_state_t;

  typedef struct packed {
    logic [15:0] on_v;
    logic [15:0] off_v;
  } pair_t;

  // x / 65535 for x up to 65535*65535: x = q0*65535 + (q0 + lo), one correction
  function automatic logic [15:0] div_65535(logic [31:0] x);
    logic [16:0] r;
    logic [15:0] q;
    r = {1'b0, x[15:0]} + {1'b0, x[31:16]};
    q = x[31:16];
    if (r >= 17'd65535) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

  function automatic pair_t calc_pair(align_t mode, logic [15:0] p, logic [15:0] h);
    pair_t       res;
    logic [15:0] half;
    logic [16:0] sum;
    half = p >> 1;
    sum  = {1'b0, p} + {1'b0, h};
    case (mode)
      ALIGN_SCENTER: begin
        res.on_v  = 16'd0 - (h >> 1);
        res.off_v = h >> 1;
      end
      ALIGN_CENTER: begin
        res.on_v  = (p - h) >> 1;
        res.off_v = sum[16:1];
      end
      ALIGN_SEDGE: begin
        res.on_v  = 16'd0 - half;
        res.off_v = (16'd0 - half) + h;
      end
      default: begin
        res.on_v  = 16'd0;
        res.off_v = h;
      end
    endcase
    return res;
  endfunction

endpackage

>>> rtl/core/pwmcalc_ctrl.sv
module pwmcalc_ctrl
  import pwmcalc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         freq_zero,
  output logic         busy,
  output logic         out_valid,
  output pwmcalc_cmd_t cmd
);

  pwmcalc_state_t   state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div_last;

  assign div_last = (cnt_r == CNT_W'(QUOT_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = freq_zero ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: state_nxt = ST_MULB;
      ST_MULB: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MULA: cmd.mul_a    = 1'b1;
      ST_MULB: cmd.mul_b    = 1'b1;
      ST_UPD:  cmd.update   = 1'b1;
      ST_DONE: out_valid    = 1'b1;
      default: busy         = 1'b1;
    endcase
  end

endmodule

>>> rtl/core/pwmcalc_dp.sv
module pwmcalc_dp
  import pwmcalc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  pwmcalc_cmd_t cmd,
  input  pwmcalc_in_t  in_data,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata,
  output logic         freq_zero,
  output pwmcalc_out_t out_data
);

  logic [31:0]  src_clk_r;
  logic [2:0]   prescale_r;
  align_t       align_r;
  logic         chan_b_r;

  logic [31:0]  divisor_r;
  logic [31:0]  quo_r;
  logic [31:0]  rem_r;
  logic [15:0]  duty_a_r;
  logic [15:0]  duty_b_r;
  logic [31:0]  prod_r;
  logic [15:0]  high_a_r;
  pwmcalc_out_t out_r;

  logic [32:0]  rem_sh;
  logic [32:0]  diff;
  logic         ge;
  logic [15:0]  period;
  logic [15:0]  half;
  logic [15:0]  high_b;
  logic [15:0]  duty_sel;
  pair_t        pair_a;
  pair_t        pair_b;

  assign freq_zero = (in_data.freq_hz == 32'd0);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_clk_r  <= SRC_CLOCK_RST;
      prescale_r <= 3'd0;
      align_r    <= ALIGN_SCENTER;
      chan_b_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SRC_CLOCK: src_clk_r  <= cfg_wdata;
        CFG_PRESCALE:  prescale_r <= cfg_wdata[2:0];
        CFG_ALIGN:     align_r    <= align_t'(cfg_wdata[1:0]);
        CFG_CHAN_B:    chan_b_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per step
  assign rem_sh = {rem_r, quo_r[QUOT_W-1]};
  assign diff   = rem_sh - {1'b0, divisor_r};
  assign ge     = !diff[32];

  assign period   = quo_r[15:0];
  assign half     = period >> 1;
  assign duty_sel = cmd.mul_b ? duty_b_r : duty_a_r;
  assign high_b   = div_65535(prod_r);
  assign pair_a   = calc_pair(align_r, period, high_a_r);
  assign pair_b   = calc_pair(align_r, period, high_b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r     <= src_clk_r >> prescale_r;
      rem_r     <= '0;
      divisor_r <= in_data.freq_hz;
      duty_a_r  <= in_data.duty_a;
      duty_b_r  <= in_data.duty_b;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      quo_r <= {quo_r[QUOT_W-2:0], ge};
    end
    if (cmd.mul_a || cmd.mul_b) begin
      prod_r <= 32'(period) * 32'(duty_sel);
    end
    if (cmd.mul_b) begin
      high_a_r <= div_65535(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (cmd.load) begin
      out_r.status <= freq_zero;
    end else if (cmd.update) begin
      if (align_r inside {ALIGN_CENTER, ALIGN_EDGE}) begin
        out_r.start_count <= 16'd0;
        out_r.mid_count   <= half;
        out_r.end_count   <= period - 16'd1;
      end else begin
        out_r.start_count <= 16'd0 - half;
        out_r.mid_count   <= 16'd0;
        out_r.end_count   <= half - 16'd1;
      end
      out_r.a_on_count  <= pair_a.on_v;
      out_r.a_off_count <= pair_a.off_v;
      if (chan_b_r) begin
        out_r.b_on_count  <= pair_b.on_v;
        out_r.b_off_count <= pair_b.off_v;
      end
    end
  end

endmodule

>>> rtl/core/pwm_period_duty_register_calc.sv
// PWM period and compare-value calculator.
// Input: pulse start with in_data (freq_hz, duty_a, duty_b) while busy is low;
// the transaction is taken at that edge and busy rises on the next cycle.
// Output: out_valid is high for one cycle with out_data (status plus the seven
// compare registers). The receiver cannot hold it off; out_data keeps its
// value until the next transaction updates it.
// Config: cfg_we/cfg_idx/cfg_wdata write src_clock_hz, prescale, align_mode and
// chan_b_present, one register per cycle; the user must write them only while
// busy is low; the block does not enforce it. The period comes from a 32-step
// restoring divider (one quotient bit per cycle), then one shared 16x16
// multiplier runs for A and then B, the update state writes the registers and
// out_valid follows. Busy stays high until idle, so transactions never overlap.
// A zero frequency skips the divider: out_valid with status 1 comes in the
// next cycle and the compare registers are left untouched.
// Reset (rst_n low, synchronous) clears the compare registers to zero, loads
// the configuration defaults (150 MHz, no prescale, signed center, no channel
// B) and returns the controller to idle.
module pwm_period_duty_register_calc
  import pwmcalc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  pwmcalc_in_t  in_data,
  output logic         out_valid,
  output pwmcalc_out_t out_data,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata
);

  `include "pwm_period_duty_register_calc_defines.svh"

  pwmcalc_cmd_t cmd;
  logic         freq_zero;

  pwmcalc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .freq_zero (freq_zero),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pwmcalc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .freq_zero (freq_zero),
    .out_data  (out_data)
  );

  `PWMCALC_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `PWMCALC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PWMCALC_ASSERT_NEXT(a_zero_freq_fast, start && !busy && in_data.freq_hz == 32'd0,
                       out_valid && out_data.status)
  `PWMCALC_ASSERT_NOW(a_strobe_while_busy, out_valid, busy)

endmodule
